// ===== rtl/cec_pkg.sv =====
// Shared constants, types and helper functions for the checkpoint envelope checker.
package cec_pkg;

    localparam int COUNT_BITS = 32;
    localparam int HDR_BYTES  = 16;
    localparam int ENV_BYTES  = 24;

    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;

    localparam logic [15:0] VERSION_RESET   = 16'd1;
    localparam logic [31:0] MAX_FRAME_RESET = 32'd1048576;

    localparam logic [7:0] MAGIC_0 = 8'h53;  // 'S'
    localparam logic [7:0] MAGIC_1 = 8'h57;  // 'W'
    localparam logic [7:0] MAGIC_2 = 8'h50;  // 'P'
    localparam logic [7:0] MAGIC_3 = 8'h53;  // 'S'

    typedef enum logic [0:0] {
        REG_EXPECTED_VERSION = 1'b0,
        REG_MAX_FRAME_BYTES  = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_LIMIT       = 4'd1,
        ST_TRUNCATED   = 4'd2,
        ST_MAGIC       = 4'd3,
        ST_VERSION     = 4'd4,
        ST_RESERVED    = 4'd5,
        ST_SHORT_PAY   = 4'd6,
        ST_TRAILING    = 4'd7,
        ST_CHECKSUM    = 4'd8
    } status_t;

    // FNV-64 prime 2^40 + 0x1B3 as shift-add
    function automatic logic [63:0] fnv_mul(input logic [63:0] x);
        fnv_mul = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0: m = MAGIC_0;
            2'd1: m = MAGIC_1;
            2'd2: m = MAGIC_2;
            default: m = MAGIC_3;
        endcase
        magic_byte = m;
    endfunction

endpackage

// ===== rtl/checkpoint_envelope_checker_unit.sv =====
// Top level: streaming frame envelope checker with FNV-1a-64 payload checksum.
//
// Usage: the s_ channel takes one buffer byte per request, s_final_byte marks
// the last byte. Each buffer yields exactly one m_ request carrying m_status
// (first failing check, 0 when the frame is good) and m_frame_bytes (byte
// count, saturating). Non-final bytes produce no output.
// Pipeline: an accepted byte lands in the input register, from which it
// updates the frame state; for a final byte m_valid rises with that update.
// Throughput is one byte per cycle unless a held result stalls a final byte,
// set by the combinational hash recurrence (xor plus shift-add constant multiply).
// Stall: a held result blocks only a final byte waiting in the input register;
// non-final bytes keep flowing while m_valid waits for m_ready.
// Configuration: cfg_wr_en writes register cfg_index (0 expected version, 1 max
// frame bytes) at once; the user writes only while idle (not enforced).
// Reset: aresetn (synchronous, active low) clears the pipeline, the frame
// state and restores the register reset values (version 1, limit 1 MiB).
module checkpoint_envelope_checker_unit
    import cec_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_final_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_status,
    output logic [31:0] m_frame_bytes
);

    logic [15:0] exp_version_reg;
    logic [31:0] max_frame_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_final_reg;

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [63:0] hash_reg, hash_next;
    logic        magic_bad_reg, magic_bad_next;
    logic [15:0] version_reg, version_next;
    logic        reserved_reg, reserved_next;
    logic [63:0] length_reg, length_next;
    logic [63:0] tail_reg, tail_next;

    logic        m_valid_reg;
    status_t     status_reg, status_next;
    logic [31:0] frame_bytes_reg, frame_bytes_next;

    logic        advance;
    logic        process;
    logic [63:0] pos;
    logic [63:0] total;
    logic [63:0] payload_len;

    assign advance = !(in_valid_reg && in_final_reg && m_valid_reg && !m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign process = in_valid_reg && advance;

    assign pos = 64'(count_reg);

    always_comb begin
        magic_bad_next = magic_bad_reg;
        version_next   = version_reg;
        reserved_next  = reserved_reg;
        length_next    = length_reg;
        hash_next      = hash_reg;

        if (pos < 64'd4) begin
            if (in_byte_reg != magic_byte(count_reg[1:0])) begin
                magic_bad_next = 1'b1;
            end
        end else if (pos < 64'd6) begin
            version_next = version_reg | (16'(in_byte_reg) << (4'(count_reg[0]) << 3));
        end else if (pos < 64'd8) begin
            if (in_byte_reg != 8'd0) begin
                reserved_next = 1'b1;
            end
        end else if (pos < 64'(HDR_BYTES)) begin
            length_next = length_reg | (64'(in_byte_reg) << (6'(count_reg[2:0]) << 3));
        end

        if (pos >= 64'(ENV_BYTES)) begin
            hash_next = fnv_mul(hash_reg ^ {56'd0, tail_reg[7:0]});
        end

        tail_next = {in_byte_reg, tail_reg[63:8]};

        if (count_reg != {COUNT_BITS{1'b1}}) begin
            count_next = count_reg + COUNT_BITS'(1);
        end else begin
            count_next = count_reg;
        end
    end

    assign total       = 64'(count_next);
    assign payload_len = total - 64'(ENV_BYTES);

    always_comb begin
        if (total > 64'(max_frame_reg)) begin
            status_next = ST_LIMIT;
        end else if (total < 64'(ENV_BYTES)) begin
            status_next = ST_TRUNCATED;
        end else if (magic_bad_next) begin
            status_next = ST_MAGIC;
        end else if (version_next != exp_version_reg) begin
            status_next = ST_VERSION;
        end else if (reserved_next) begin
            status_next = ST_RESERVED;
        end else if (length_next > payload_len) begin
            status_next = ST_SHORT_PAY;
        end else if (length_next != payload_len) begin
            status_next = ST_TRAILING;
        end else if (hash_next != tail_next) begin
            status_next = ST_CHECKSUM;
        end else begin
            status_next = ST_OK;
        end

        if (total > 64'hFFFF_FFFF) begin
            frame_bytes_next = 32'hFFFF_FFFF;
        end else begin
            frame_bytes_next = total[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_version_reg <= VERSION_RESET;
            max_frame_reg   <= MAX_FRAME_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_EXPECTED_VERSION: exp_version_reg <= cfg_wdata[15:0];
                REG_MAX_FRAME_BYTES:  max_frame_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg  <= s_data_byte;
            in_final_reg <= s_final_byte;
        end
    end

    // frame state: cleared after the final byte
    always_ff @(posedge aclk) begin
        if (!aresetn || (process && in_final_reg)) begin
            count_reg     <= '0;
            hash_reg      <= FNV_BASIS;
            magic_bad_reg <= 1'b0;
            version_reg   <= '0;
            reserved_reg  <= 1'b0;
            length_reg    <= '0;
            tail_reg      <= '0;
        end else if (process) begin
            count_reg     <= count_next;
            hash_reg      <= hash_next;
            magic_bad_reg <= magic_bad_next;
            version_reg   <= version_next;
            reserved_reg  <= reserved_next;
            length_reg    <= length_next;
            tail_reg      <= tail_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (process && in_final_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (process && in_final_reg) begin
            status_reg      <= status_next;
            frame_bytes_reg <= frame_bytes_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_frame_bytes = frame_bytes_reg;

endmodule
